/* hdl/ctt_pkg.sv */
package ctt_pkg;

  localparam int TABLE_ENTRIES_DEF  = 256;
  localparam int CLEANUP_PERIOD_DEF = 1000;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] FUNC_PACKET  = 2'd0;
  localparam logic [1:0] FUNC_REMOVE  = 2'd1;
  localparam logic [1:0] FUNC_CLEANUP = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [1:0] FLOW_NONE = 2'd0;
  localparam logic [1:0] FLOW_SYN  = 2'd1;
  localparam logic [1:0] FLOW_EST  = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TCP_INIT_TO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UDP_TO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EST_TO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_TO    = 3'd4;

  localparam logic [8:0]  MAX_FLOWS_RST   = 9'd256;
  localparam logic [31:0] TCP_INIT_TO_RST = 32'd10;
  localparam logic [31:0] UDP_TO_RST      = 32'd30;
  localparam logic [31:0] EST_TO_RST      = 32'd432000;
  localparam logic [31:0] OTHER_TO_RST    = 32'd300;

  localparam logic [8:0] EVICT_MAX = 9'd511;

  typedef struct packed {
    logic [8:0]  max_flows;
    logic [31:0] tcp_initial_timeout;
    logic [31:0] udp_timeout;
    logic [31:0] established_timeout;
    logic [31:0] other_timeout;
  } cfg_regs_t;

  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  pr;
  } flow_key_t;

  typedef struct packed {
    logic [1:0]  flow_state;
    logic [31:0] timeout;
    logic [31:0] seen_at;
    logic [31:0] orig_packets;
    logic [31:0] reply_packets;
    logic        reply_seen;
    logic [31:0] seq;
    logic [31:0] ack;
  } entry_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOD,
    ST_DONE
  } ctl_state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

/* hdl/ctt_ram.sv */
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ctt_cfg.sv */
module ctt_cfg import ctt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_regs_t            regs
);

  // decode register writes, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_flows           <= MAX_FLOWS_RST;
      regs.tcp_initial_timeout <= TCP_INIT_TO_RST;
      regs.udp_timeout         <= UDP_TO_RST;
      regs.established_timeout <= EST_TO_RST;
      regs.other_timeout       <= OTHER_TO_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_FLOWS:   regs.max_flows           <= cfg_data[8:0];
        CFG_TCP_INIT_TO: regs.tcp_initial_timeout <= cfg_data;
        CFG_UDP_TO:      regs.udp_timeout         <= cfg_data;
        CFG_EST_TO:      regs.established_timeout <= cfg_data;
        CFG_OTHER_TO:    regs.other_timeout       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/connection_tracking_table_core.sv */
// Flow table keyed by the five-tuple, held in a key memory and an entry-data
// memory, with per-entry valid flops cleared at reset (no clearing pass).
// A packet word scans every key through the memory read port, one entry per
// cycle, then passes the decide, update and done states, where its result is
// registered; a remove word, or a packet with no room, skips the update step.
// A cleanup tick goes straight to done, except every CLEANUP_PERIOD-th tick,
// which scans the entry data for idle flows. One word is worked on at a time;
// a finished result waits in the output register as the next word is accepted.
module connection_tracking_table_core import ctt_pkg::*; #(
  parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
  parameter int CLEANUP_PERIOD = CLEANUP_PERIOD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [31:0]          src_addr,
  input  logic [31:0]          dst_addr,
  input  logic [15:0]          src_port_num,
  input  logic [15:0]          dst_port_num,
  input  logic [7:0]           proto,
  input  logic                 is_reply,
  input  logic [31:0]          seq_num,
  input  logic [31:0]          ack_num,
  input  logic [31:0]          now_seconds,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 created,
  output logic [1:0]           flow_state,
  output logic [31:0]          orig_packets,
  output logic [31:0]          reply_packets,
  output logic                 reply_seen,
  output logic [8:0]           evicted_count
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int MW = (CW > 9) ? CW : 9;
  localparam int TW = $clog2(CLEANUP_PERIOD + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam int KW = $bits(flow_key_t);
  localparam int DW = $bits(entry_data_t);

  cfg_regs_t cfg;

  ctt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  ctl_state_t state, state_next;

  // held word
  logic [1:0]  item_func;
  flow_key_t   item_key;
  logic        item_reply;
  logic [31:0] item_seq;
  logic [31:0] item_ack;
  logic [31:0] item_now;

  // table control state
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0]            flow_count;
  logic [TW-1:0]            tick_count;

  // scan bookkeeping
  logic [AW-1:0] scan_idx;
  logic          issue_done;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic          orig_hit, reply_hit, free_hit;
  logic [AW-1:0] orig_idx, reply_idx, free_idx;
  logic [AW-1:0] e_idx;
  logic          make_new;

  // result held until the output register frees
  logic [1:0]  res_status;
  logic        res_created;
  logic [1:0]  res_state;
  logic [31:0] res_orig;
  logic [31:0] res_reply;
  logic        res_rs;
  logic [8:0]  res_ev;

  // memories
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic          key_we, data_we;
  flow_key_t     key_rdata;
  entry_data_t   data_rdata, data_wdata;

  ctt_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (e_idx),
    .wdata (item_key),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (key_rdata)
  );

  ctt_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (e_idx),
    .wdata (data_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (data_rdata)
  );

  logic in_acc;
  logic scan_last;
  logic [TW-1:0] tick_inc;
  logic tick_fire;
  logic room;
  logic decide_fail;
  logic cmp_orig, cmp_reply, cmp_idle;

  assign in_acc    = in_valid && !in_stall;
  assign scan_last = rd_pend && (rd_idx == LAST_IDX);
  assign tick_inc  = tick_count + TW'(1);
  assign tick_fire = tick_inc >= TW'(CLEANUP_PERIOD);
  assign room      = (MW'(flow_count) < MW'(cfg.max_flows)) && free_hit;
  assign decide_fail = (item_func == FUNC_PACKET) && !orig_hit && !reply_hit && !room;

  // key compare and idle test on the word returned by the memories
  assign cmp_orig  = (key_rdata == item_key);
  assign cmp_reply = (key_rdata.da == item_key.sa) && (key_rdata.sa == item_key.da) &&
                     (key_rdata.dp == item_key.sp) && (key_rdata.sp == item_key.dp) &&
                     (key_rdata.pr == item_key.pr);
  assign cmp_idle  = (item_now >= data_rdata.seen_at) &&
                     ((item_now - data_rdata.seen_at) > data_rdata.timeout);

  // build the updated entry for a packet
  always_comb begin
    entry_data_t base;
    if (make_new) begin
      base.flow_state    = FLOW_NONE;
      base.timeout       = (item_key.pr == PROTO_TCP) ? cfg.tcp_initial_timeout :
                           (item_key.pr == PROTO_UDP) ? cfg.udp_timeout :
                           cfg.other_timeout;
      base.seen_at       = '0;
      base.orig_packets  = '0;
      base.reply_packets = '0;
      base.reply_seen    = 1'b0;
      base.seq           = '0;
      base.ack           = '0;
    end else begin
      base = data_rdata;
    end
    data_wdata = base;
    data_wdata.seen_at = item_now;
    if (!item_reply) begin
      data_wdata.orig_packets = sat_inc(base.orig_packets);
    end else begin
      data_wdata.reply_packets = sat_inc(base.reply_packets);
      data_wdata.reply_seen    = 1'b1;
    end
    if (item_key.pr == PROTO_TCP) begin
      if (base.flow_state == FLOW_NONE) begin
        data_wdata.flow_state = FLOW_SYN;
      end else if (base.flow_state == FLOW_SYN && item_reply) begin
        data_wdata.flow_state = FLOW_EST;
        data_wdata.timeout    = cfg.established_timeout;
      end
      if (item_seq != '0) data_wdata.seq = item_seq;
      if (item_ack != '0) data_wdata.ack = item_ack;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_PACKET || func == FUNC_REMOVE ||
              (func == FUNC_CLEANUP && tick_fire)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (item_func == FUNC_PACKET && !decide_fail) state_next = ST_MOD;
        else state_next = ST_DONE;
      end
      ST_MOD:  state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = scan_idx;
    key_we    = 1'b0;
    data_we   = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_SCAN: ram_re = !issue_done;
      ST_DECIDE: begin
        ram_re    = 1'b1;
        ram_raddr = orig_hit ? orig_idx : reply_idx;
      end
      ST_MOD: begin
        data_we = 1'b1;
        key_we  = make_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      flow_count <= '0;
      tick_count <= '0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= ram_re && (state == ST_SCAN);
      rd_idx  <= scan_idx;

      // drop the taken result unless a new one loads this cycle
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            item_func         <= func;
            item_key          <= '{src_addr, dst_addr, src_port_num, dst_port_num, proto};
            item_reply        <= is_reply;
            item_seq          <= seq_num;
            item_ack          <= ack_num;
            item_now          <= now_seconds;
            scan_idx          <= '0;
            issue_done        <= 1'b0;
            orig_hit          <= 1'b0;
            reply_hit         <= 1'b0;
            free_hit          <= 1'b0;
            make_new          <= 1'b0;
            res_status        <= STATUS_OK;
            res_created       <= 1'b0;
            res_state         <= FLOW_NONE;
            res_orig          <= '0;
            res_reply         <= '0;
            res_rs            <= 1'b0;
            res_ev            <= '0;
            if (func == FUNC_CLEANUP) begin
              tick_count <= tick_fire ? '0 : tick_inc;
            end
          end
        end
        ST_SCAN: begin
          // advance the read address
          if (!issue_done) begin
            scan_idx <= scan_idx + AW'(1);
            if (scan_idx == LAST_IDX) issue_done <= 1'b1;
          end
          // compare the returned entry
          if (rd_pend) begin
            if (item_func == FUNC_CLEANUP) begin
              if (valid[rd_idx] && cmp_idle) begin
                valid[rd_idx] <= 1'b0;
                if (flow_count != '0) flow_count <= flow_count - CW'(1);
                if (res_ev != EVICT_MAX) res_ev <= res_ev + 9'd1;
              end
            end else if (valid[rd_idx]) begin
              if (cmp_orig && !orig_hit) begin
                orig_hit <= 1'b1;
                orig_idx <= rd_idx;
              end
              if (cmp_reply && !reply_hit) begin
                reply_hit <= 1'b1;
                reply_idx <= rd_idx;
              end
            end else if (!free_hit) begin
              free_hit <= 1'b1;
              free_idx <= rd_idx;
            end
          end
        end
        ST_DECIDE: begin
          case (item_func)
            FUNC_PACKET: begin
              if (decide_fail) begin
                res_status <= STATUS_FULL;
              end else begin
                make_new <= !orig_hit && !reply_hit;
                e_idx    <= orig_hit ? orig_idx : reply_hit ? reply_idx : free_idx;
              end
            end
            FUNC_REMOVE: begin
              if (orig_hit) begin
                valid[orig_idx] <= 1'b0;
                if (flow_count != '0) flow_count <= flow_count - CW'(1);
              end else begin
                res_status <= STATUS_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
        ST_MOD: begin
          // commit the entry and hold its view for the result
          valid[e_idx] <= 1'b1;
          if (make_new) flow_count <= flow_count + CW'(1);
          res_created <= make_new;
          res_state   <= data_wdata.flow_state;
          res_orig    <= data_wdata.orig_packets;
          res_reply   <= data_wdata.reply_packets;
          res_rs      <= data_wdata.reply_seen;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            created       <= res_created;
            flow_state    <= res_state;
            orig_packets  <= res_orig;
            reply_packets <= res_reply;
            reply_seen    <= res_rs;
            evicted_count <= res_ev;
          end
        end
        default: ;
      endcase
    end
  end

  // the flow count tracks the valid flops exactly
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    CW'($countones(valid)) == flow_count)
    else $error("flow count differs from valid entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    MW'(flow_count) <= MW'(TABLE_ENTRIES))
    else $error("flow count above table size");

  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && created |-> status == STATUS_OK && evicted_count == '0)
    else $error("created flow with failing status");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != ST_IDLE)
    else $error("accepted word left controller idle");

endmodule

/* bench/ctt_checker.sv */
// Watches both channels of the flow table, keeps its own copy of the table,
// predicts one result per accepted word and compares field by field.
module ctt_checker import ctt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [31:0]          src_addr,
  input  logic [31:0]          dst_addr,
  input  logic [15:0]          src_port_num,
  input  logic [15:0]          dst_port_num,
  input  logic [7:0]           proto,
  input  logic                 is_reply,
  input  logic [31:0]          seq_num,
  input  logic [31:0]          ack_num,
  input  logic [31:0]          now_seconds,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           status,
  input  logic                 created,
  input  logic [1:0]           flow_state,
  input  logic [31:0]          orig_packets,
  input  logic [31:0]          reply_packets,
  input  logic                 reply_seen,
  input  logic [8:0]           evicted_count,
  output int                   fail_count,
  output int                   pending,
  output int                   created_total,
  output int                   evicted_total,
  output int                   full_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = TABLE_ENTRIES_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic        created;
    logic [1:0]  flow_state;
    logic [31:0] orig_packets;
    logic [31:0] reply_packets;
    logic        reply_seen;
    logic [8:0]  evicted;
  } conn_result_t;

  logic        flow_live [NENT];
  flow_key_t   flow_keys [NENT];
  entry_data_t flow_info [NENT];
  logic [8:0]  live_flows;
  int          tick_calls;
  cfg_regs_t   regs;
  conn_result_t expected_results [$];

  function automatic int find_flow(flow_key_t k, bit reversed);
    flow_key_t r;
    r = k;
    if (reversed) begin
      r.sa = k.da; r.da = k.sa; r.sp = k.dp; r.dp = k.sp;
    end
    for (int i = 0; i < NENT; i++)
      if (flow_live[i] && flow_keys[i] == r) return i;
    return -1;
  endfunction

  // Apply one word to the table copy and return the result it should give
  function automatic conn_result_t track_word(logic [1:0] f, flow_key_t k, logic rep,
                                              logic [31:0] sq, logic [31:0] ak,
                                              logic [31:0] now);
    conn_result_t r;
    int e;
    logic made;
    entry_data_t d;
    r = '0;
    made = 1'b0;
    case (f)
      FUNC_PACKET: begin
        e = find_flow(k, 1'b0);
        if (e < 0) e = find_flow(k, 1'b1);
        if (e < 0) begin
          if (live_flows < regs.max_flows)
            for (int i = 0; i < NENT; i++)
              if (!flow_live[i]) begin
                e = i;
                break;
              end
          if (e < 0) begin
            r.status = STATUS_FULL;
            full_total++;
            return r;
          end
          flow_live[e] = 1'b1;
          flow_keys[e] = k;
          d = '0;
          d.flow_state = FLOW_NONE;
          d.timeout = (k.pr == PROTO_TCP) ? regs.tcp_initial_timeout :
                      (k.pr == PROTO_UDP) ? regs.udp_timeout : regs.other_timeout;
          flow_info[e] = d;
          live_flows++;
          made = 1'b1;
          created_total++;
        end
        d = flow_info[e];
        d.seen_at = now;
        if (!rep) begin
          if (d.orig_packets != '1) d.orig_packets++;
        end else begin
          if (d.reply_packets != '1) d.reply_packets++;
          d.reply_seen = 1'b1;
        end
        // Advance the TCP handshake and keep nonzero seq/ack
        if (k.pr == PROTO_TCP) begin
          if (d.flow_state == FLOW_NONE) begin
            d.flow_state = FLOW_SYN;
          end else if (d.flow_state == FLOW_SYN && rep) begin
            d.flow_state = FLOW_EST;
            d.timeout = regs.established_timeout;
          end
          if (sq != 0) d.seq = sq;
          if (ak != 0) d.ack = ak;
        end
        flow_info[e] = d;
        r.created = made;
        r.flow_state = d.flow_state;
        r.orig_packets = d.orig_packets;
        r.reply_packets = d.reply_packets;
        r.reply_seen = d.reply_seen;
      end
      FUNC_REMOVE: begin
        e = find_flow(k, 1'b0);
        if (e < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          flow_live[e] = 1'b0;
          if (live_flows > 0) live_flows--;
        end
      end
      FUNC_CLEANUP: begin
        tick_calls++;
        if (tick_calls >= CLEANUP_PERIOD_DEF) begin
          tick_calls = 0;
          // Drop idle flows; a timestamp in the future never ages out
          for (int i = 0; i < NENT; i++)
            if (flow_live[i] && now >= flow_info[i].seen_at &&
                now - flow_info[i].seen_at > flow_info[i].timeout) begin
              flow_live[i] = 1'b0;
              if (live_flows > 0) live_flows--;
              if (r.evicted != EVICT_MAX) r.evicted++;
            end
          evicted_total += r.evicted;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    conn_result_t exp_r;
    conn_result_t got;
    if (rst) begin
      for (int i = 0; i < NENT; i++) flow_live[i] = 1'b0;
      live_flows = '0;
      tick_calls = 0;
      regs = '{MAX_FLOWS_RST, TCP_INIT_TO_RST, UDP_TO_RST, EST_TO_RST, OTHER_TO_RST};
      expected_results.delete();
      fail_count = 0;
      created_total = 0;
      evicted_total = 0;
      full_total = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAX_FLOWS:   regs.max_flows = cfg_data[8:0];
          CFG_TCP_INIT_TO: regs.tcp_initial_timeout = cfg_data;
          CFG_UDP_TO:      regs.udp_timeout = cfg_data;
          CFG_EST_TO:      regs.established_timeout = cfg_data;
          CFG_OTHER_TO:    regs.other_timeout = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_results.push_back(track_word(func,
          '{src_addr, dst_addr, src_port_num, dst_port_num, proto},
          is_reply, seq_num, ack_num, now_seconds));
      if (out_valid && !out_stall) begin
        got = '{status, created, flow_state, orig_packets, reply_packets,
                reply_seen, evicted_count};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with nothing expected: %h", $realtime, got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch expected st=%0d cr=%0d fs=%0d op=%0d rp=%0d",
                        " rs=%0d ev=%0d, got st=%0d cr=%0d fs=%0d op=%0d rp=%0d",
                        " rs=%0d ev=%0d"}, $realtime,
                       exp_r.status, exp_r.created, exp_r.flow_state,
                       exp_r.orig_packets, exp_r.reply_packets, exp_r.reply_seen,
                       exp_r.evicted, got.status, got.created, got.flow_state,
                       got.orig_packets, got.reply_packets, got.reply_seen,
                       got.evicted);
          end
        end
      end
    end
  end
endmodule

/* bench/tb_top.sv */
module tb_top import ctt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           func = '0;
  logic [31:0]          src_addr = '0;
  logic [31:0]          dst_addr = '0;
  logic [15:0]          src_port_num = '0;
  logic [15:0]          dst_port_num = '0;
  logic [7:0]           proto = '0;
  logic                 is_reply = 1'b0;
  logic [31:0]          seq_num = '0;
  logic [31:0]          ack_num = '0;
  logic [31:0]          now_seconds = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic                 created;
  logic [1:0]           flow_state;
  logic [31:0]          orig_packets;
  logic [31:0]          reply_packets;
  logic                 reply_seen;
  logic [8:0]           evicted_count;

  int fail_count, pending, created_total, evicted_total, full_total;
  int words_sent = 0;
  bit calm = 1'b0;
  bit held = 1'b0;
  flow_key_t flow_pool [24];
  logic [31:0] wall_clock = 32'd1000;

  connection_tracking_table_core dut (.*);
  ctt_checker u_checker (.*);

  initial forever #4 clk = ~clk;

  initial begin
    repeat (4_000_000) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none in the calm part
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && words_sent >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic flow_key_t flip(flow_key_t k);
    return '{k.da, k.sa, k.dp, k.sp, k.pr};
  endfunction

  function automatic flow_key_t any_key(logic [7:0] pr);
    return '{$urandom, $urandom, 16'($urandom), 16'($urandom), pr};
  endfunction

  // Hold one word until accepted; unless calm, it may then idle before returning
  task automatic send(logic [1:0] f, flow_key_t k, logic rep, logic [31:0] sq,
                      logic [31:0] ak, logic [31:0] now);
    in_valid <= 1'b1;
    func <= f;
    {src_addr, dst_addr, src_port_num, dst_port_num, proto} <= k;
    is_reply <= rep;
    seq_num <= sq;
    ack_num <= ak;
    now_seconds <= now;
    forever begin
      @(negedge clk);
      if (!in_stall) begin
        @(posedge clk);
        break;
      end
    end
    words_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(logic [8:0] mx, logic [31:0] tcp, logic [31:0] udp,
                          logic [31:0] est, logic [31:0] oth);
    logic [31:0] vals [5];
    vals = '{32'(mx), tcp, udp, est, oth};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fresh_pool();
    for (int i = 0; i < 24; i++)
      flow_pool[i] = any_key((i % 3 == 0) ? PROTO_TCP : (i % 3 == 1) ? PROTO_UDP
                             : 8'($urandom));
  endtask

  function automatic logic [31:0] maybe_zero();
    return ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
  endfunction

  function automatic logic [31:0] pick_time();
    wall_clock += $urandom_range(0, 40);
    return ($urandom_range(0, 19) == 0) ? $urandom : wall_clock + $urandom_range(0, 5);
  endfunction

  // One random word: mostly pool traffic, some noise, removes, ticks and unused codes
  task automatic random_word();
    int r;
    flow_key_t k;
    logic rep;
    r = $urandom_range(0, 99);
    k = flow_pool[$urandom_range(0, 23)];
    rep = 1'($urandom);
    if (r < 62) begin
      send(FUNC_PACKET, rep ? flip(k) : k, rep, maybe_zero(), maybe_zero(), pick_time());
    end else if (r < 70) begin
      send(FUNC_PACKET, any_key($urandom_range(0, 1) ? PROTO_TCP : 8'($urandom)),
           rep, maybe_zero(), maybe_zero(), pick_time());
    end else if (r < 80) begin
      if ($urandom_range(0, 9) < 7) k = rep ? flip(k) : k;
      else k = any_key(8'($urandom));
      send(FUNC_REMOVE, k, rep, $urandom, $urandom, $urandom);
    end else if (r < 97) begin
      send(FUNC_CLEANUP, any_key(8'($urandom)), rep, $urandom, $urandom, pick_time());
    end else begin
      send(FUNC_UNUSED, any_key(8'($urandom)), rep, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    flow_key_t k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: handshake, removes, protocols, extremes, unused code, filling up
    set_regs(9'd8, 32'd10, 32'd30, 32'd1000, 32'd300);
    fresh_pool();
    k = flow_pool[0];
    send(FUNC_PACKET, k, 1'b0, 32'd100, 32'd0, 32'd1000);
    send(FUNC_PACKET, flip(k), 1'b1, 32'd0, 32'd101, 32'd1001);
    send(FUNC_PACKET, k, 1'b0, 32'd0, 32'd0, 32'd1002);
    send(FUNC_REMOVE, flip(k), 1'b0, 32'd0, 32'd0, 32'd1003);
    send(FUNC_REMOVE, k, 1'b0, 32'd0, 32'd0, 32'd1003);
    send(FUNC_REMOVE, k, 1'b0, 32'd0, 32'd0, 32'd1004);
    send(FUNC_PACKET, flow_pool[1], 1'b0, 32'd5, 32'd6, 32'd1005);
    send(FUNC_PACKET, flip(flow_pool[1]), 1'b1, 32'd0, 32'd0, 32'd1006);
    send(FUNC_PACKET, flow_pool[2], 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send(FUNC_PACKET, '1, 1'b1, '1, '1, '1);
    send(FUNC_PACKET, '0, 1'b0, '0, '0, '0);
    send(FUNC_UNUSED, '1, 1'b1, '1, '1, '1);
    send(FUNC_CLEANUP, '0, 1'b0, '0, '0, 32'd2000);
    for (int i = 0; i < 6; i++)
      send(FUNC_PACKET, any_key(PROTO_UDP), 1'b0, 32'd0, 32'd0, 32'd2000);
    for (int i = 0; i < 250; i++) random_word();
    settle();

    // No room at all
    set_regs(9'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < 5; i++)
      send(FUNC_PACKET, any_key(PROTO_TCP), 1'b0, $urandom, $urandom, pick_time());
    settle();

    // Tiny table with zero initial, UDP and other timeouts
    set_regs(9'd3, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    fresh_pool();
    for (int i = 0; i < 150; i++) random_word();
    settle();

    // Limit above the entry count: fill every entry, then overflow
    set_regs(9'd511, 32'hFFFF_FFFF, 32'd1, 32'd2, 32'd3);
    fresh_pool();
    for (int i = 0; i < TABLE_ENTRIES_DEF + 4; i++)
      send(FUNC_PACKET, any_key(PROTO_UDP), 1'($urandom), 32'd0, 32'd0, wall_clock);
    for (int i = 0; i < 100; i++) random_word();
    settle();

    // Reset-value settings, no idling on either side
    set_regs(MAX_FLOWS_RST, TCP_INIT_TO_RST, UDP_TO_RST, EST_TO_RST, OTHER_TO_RST);
    calm = 1'b1;
    fresh_pool();
    for (int i = 0; i < 120; i++) random_word();
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d words: %0d flows created, %0d table-full refusals,", words_sent,
             created_total, full_total);
    $display("%0d flows aged out, over five register settings.", evicted_total);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* connection_tracking_table_core.f */
hdl/ctt_pkg.sv
hdl/ctt_ram.sv
hdl/ctt_cfg.sv
hdl/connection_tracking_table_core.sv
bench/ctt_checker.sv
bench/tb_top.sv
